@@ rtl/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants for the cell charge state tracker.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int FIELD_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CODE_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

    localparam logic [CFG_W-1:0] VOLTAGE_LIMIT_RST = 16'hFFFF;
    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 16'd10;

    // temperature code offset, applied modulo 256
    localparam logic [CODE_W-1:0] TEMP_OFFSET = 8'd150;

    // charge state codes as seen on the result channel
    localparam logic [1:0] CODE_INIT        = 2'd0;
    localparam logic [1:0] CODE_CHARGING    = 2'd1;
    localparam logic [1:0] CODE_CHARGED     = 2'd2;
    localparam logic [1:0] CODE_DISCHARGING = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT        = 4'b0001,
        ST_CHARGING    = 4'b0010,
        ST_CHARGED     = 4'b0100,
        ST_DISCHARGING = 4'b1000
    } t_charge_state;

    // window tracker -> charge machine
    typedef struct packed {
        logic window_end;
        logic t_up;
        logic v_up;
        logic over_limit;
    } t_win_status;

    // charge machine -> result register
    typedef struct packed {
        logic [1:0] charge_state;
        logic       overvoltage;
        logic       bypass;
    } t_charge_out;

    typedef struct packed {
        logic [1:0]        charge_state;
        logic              overvoltage;
        logic              bypass;
        logic              window_end;
        logic [CODE_W-1:0] max_temp_code;
        logic [CODE_W-1:0] min_temp_code;
    } t_result;

endpackage

@@ rtl/cct_sample_if.sv @@
// ----------------------------------------------------------------------------
// cct_sample_if
// Sample channel: one temperature / voltage pair per item.
// ----------------------------------------------------------------------------
interface cct_sample_if;
    logic                        valid;
    logic                        ready;
    logic [cct_pkg::FIELD_W-1:0] temp_raw;
    logic [cct_pkg::FIELD_W-1:0] cell_voltage;

    modport source (output valid, output temp_raw, output cell_voltage, input ready);
    modport sink   (input valid, input temp_raw, input cell_voltage, output ready);
endinterface

@@ rtl/cct_result_if.sv @@
// ----------------------------------------------------------------------------
// cct_result_if
// Result channel: charge state, flags and temperature codes per item.
// ----------------------------------------------------------------------------
interface cct_result_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 charge_state;
    logic                       overvoltage;
    logic                       bypass;
    logic                       window_end;
    logic [cct_pkg::CODE_W-1:0] max_temp_code;
    logic [cct_pkg::CODE_W-1:0] min_temp_code;

    modport source (output valid, output charge_state, output overvoltage,
                    output bypass, output window_end, output max_temp_code,
                    output min_temp_code, input ready);
    modport sink   (input valid, input charge_state, input overvoltage,
                    input bypass, input window_end, input max_temp_code,
                    input min_temp_code, output ready);
endinterface

@@ rtl/cct_window.sv @@
// ----------------------------------------------------------------------------
// cct_window
// Window tracker: sample count, running extremes, previous-window extremes
// and the rising / overvoltage compares at window end.
// ----------------------------------------------------------------------------
module cct_window #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [cct_pkg::FIELD_W-1:0] i_temp_raw,
    input  logic [cct_pkg::FIELD_W-1:0] i_cell_voltage,
    input  logic [cct_pkg::CFG_W-1:0]   i_voltage_limit,
    input  logic [cct_pkg::CFG_W-1:0]   i_window_length,
    output cct_pkg::t_win_status        o_status,
    output logic [cct_pkg::CODE_W-1:0]  o_max_temp_code,
    output logic [cct_pkg::CODE_W-1:0]  o_min_temp_code
);

    logic [cct_pkg::FIELD_W-1:0]    r_phase;
    logic signed [SAMPLE_WIDTH-1:0] r_tmax, r_tmin, r_ptmax, r_ptmin;
    logic [SAMPLE_WIDTH-1:0]        r_vmax, r_vmin, r_pvmax, r_pvmin;

    logic [SAMPLE_WIDTH-1:0]        w_mag_ext;
    logic signed [SAMPLE_WIDTH-1:0] w_temp;
    logic [SAMPLE_WIDTH-1:0]        w_volt;
    logic                           w_first;
    logic signed [SAMPLE_WIDTH-1:0] w_tmax_base, w_tmin_base;
    logic [SAMPLE_WIDTH-1:0]        w_vmax_base, w_vmin_base;
    logic signed [SAMPLE_WIDTH-1:0] n_tmax, n_tmin;
    logic [SAMPLE_WIDTH-1:0]        n_vmax, n_vmin;
    logic [cct_pkg::FIELD_W:0]      w_next;
    logic                           w_end;

    // sign-magnitude decode; negative zero falls out as zero
    assign w_mag_ext = {1'b0, i_temp_raw[SAMPLE_WIDTH-2:0]};
    assign w_temp    = i_temp_raw[SAMPLE_WIDTH-1] ? $signed(-w_mag_ext) : $signed(w_mag_ext);
    assign w_volt    = i_cell_voltage[SAMPLE_WIDTH-1:0];

    // restart the extremes on the first sample of a window
    assign w_first     = (r_phase == '0);
    assign w_tmax_base = w_first ? w_temp : r_tmax;
    assign w_tmin_base = w_first ? w_temp : r_tmin;
    assign w_vmax_base = w_first ? w_volt : r_vmax;
    assign w_vmin_base = w_first ? w_volt : r_vmin;

    assign n_tmax = (w_temp > w_tmax_base) ? w_temp : w_tmax_base;
    assign n_tmin = (w_temp < w_tmin_base) ? w_temp : w_tmin_base;
    assign n_vmax = (w_volt > w_vmax_base) ? w_volt : w_vmax_base;
    assign n_vmin = (w_volt < w_vmin_base) ? w_volt : w_vmin_base;

    assign w_next = {1'b0, r_phase} + {{cct_pkg::FIELD_W{1'b0}}, 1'b1};
    assign w_end  = (w_next >= {1'b0, i_window_length});

    assign o_status.window_end = w_end;
    assign o_status.t_up       = (n_tmax >= r_ptmax) || (n_tmin >= r_ptmin);
    assign o_status.v_up       = (n_vmax >= r_pvmax) || (n_vmin >= r_pvmin);
    assign o_status.over_limit = (cct_pkg::CFG_W'(n_vmin) > i_voltage_limit);

    assign o_max_temp_code = n_tmax[cct_pkg::CODE_W-1:0] - cct_pkg::TEMP_OFFSET;
    assign o_min_temp_code = n_tmin[cct_pkg::CODE_W-1:0] - cct_pkg::TEMP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_tmax  <= '0;
            r_tmin  <= '0;
            r_ptmax <= '0;
            r_ptmin <= '0;
            r_vmax  <= '0;
            r_vmin  <= '0;
            r_pvmax <= '0;
            r_pvmin <= '0;
        end else if (i_en) begin
            r_tmax <= n_tmax;
            r_tmin <= n_tmin;
            r_vmax <= n_vmax;
            r_vmin <= n_vmin;
            if (w_end) begin
                r_phase <= '0;
                r_ptmax <= n_tmax;
                r_ptmin <= n_tmin;
                r_pvmax <= n_vmax;
                r_pvmin <= n_vmin;
            end else begin
                r_phase <= w_next[cct_pkg::FIELD_W-1:0];
            end
        end
    end

    a_phase_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_end |=> r_phase == '0)
        else $error("window count did not restart after window end");

endmodule

@@ rtl/cct_charge_fsm.sv @@
// ----------------------------------------------------------------------------
// cct_charge_fsm
// Four-state charge machine and overvoltage flag, stepped at window end.
// ----------------------------------------------------------------------------
module cct_charge_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  cct_pkg::t_win_status i_status,
    output cct_pkg::t_charge_out o_charge
);

    cct_pkg::t_charge_state r_state, n_state, w_step;
    logic                   r_flag, n_flag;
    logic                   w_up;
    logic                   w_step_en;
    logic [1:0]             w_code;

    assign w_up      = i_status.t_up || i_status.v_up;
    assign w_step_en = i_en && i_status.window_end;

    always_comb begin
        unique case (r_state)
            cct_pkg::ST_INIT: begin
                w_step = w_up ? cct_pkg::ST_CHARGING : cct_pkg::ST_DISCHARGING;
            end
            cct_pkg::ST_CHARGING: begin
                w_step = w_up ? cct_pkg::ST_CHARGED : cct_pkg::ST_DISCHARGING;
            end
            cct_pkg::ST_CHARGED: begin
                w_step = w_up ? cct_pkg::ST_CHARGED : cct_pkg::ST_DISCHARGING;
            end
            cct_pkg::ST_DISCHARGING: begin
                w_step = i_status.t_up ? cct_pkg::ST_CHARGING : cct_pkg::ST_DISCHARGING;
            end
            default: begin
                w_step = cct_pkg::ST_INIT;
            end
        endcase
    end

    assign n_state = w_step_en ? w_step : r_state;
    assign n_flag  = w_step_en ? i_status.over_limit : r_flag;

    // report the state as it stands after this item
    always_comb begin
        unique case (n_state)
            cct_pkg::ST_INIT:        w_code = cct_pkg::CODE_INIT;
            cct_pkg::ST_CHARGING:    w_code = cct_pkg::CODE_CHARGING;
            cct_pkg::ST_CHARGED:     w_code = cct_pkg::CODE_CHARGED;
            cct_pkg::ST_DISCHARGING: w_code = cct_pkg::CODE_DISCHARGING;
            default:                 w_code = cct_pkg::CODE_INIT;
        endcase
    end

    assign o_charge.charge_state = w_code;
    assign o_charge.overvoltage  = n_flag;
    assign o_charge.bypass       = (n_state == cct_pkg::ST_CHARGED) || n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cct_pkg::ST_INIT;
            r_flag  <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
            r_flag  <= n_flag;
        end
    end

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step_en |=> $stable(r_state) && $stable(r_flag))
        else $error("charge state moved outside a window end");

endmodule

@@ rtl/cell_charge_state_tracker.sv @@
// ----------------------------------------------------------------------------
// cell_charge_state_tracker
// Windowed min/max tracking of cell temperature and voltage with a
// four-state charge machine stepped at every window end.
// ----------------------------------------------------------------------------
// One result item leaves for every sample item taken, in order. The block
// takes one sample per clock unless the result channel stalls: a sample
// is held in the input register, then the window tracker and the charge
// machine update their state as the result register is loaded. That state
// update is the loop that sets the rate. Result fields show the charge
// state after each item and its window's extremes including that sample;
// window_end marks the sample that closed a window. Configuration writes
// take effect on the next sample and should be made while the block is idle.
module cell_charge_state_tracker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cct_pkg::CFG_W-1:0]     i_cfg_data,
    cct_sample_if.sink                    i_sample,
    cct_result_if.source                  o_result
);

    logic [cct_pkg::CFG_W-1:0]   r_voltage_limit;
    logic [cct_pkg::CFG_W-1:0]   r_window_length;

    logic                        r_in_valid;
    logic [cct_pkg::FIELD_W-1:0] r_in_temp;
    logic [cct_pkg::FIELD_W-1:0] r_in_volt;

    logic                        r_out_valid;
    cct_pkg::t_result            r_res;
    cct_pkg::t_result            n_res;

    logic                        w_out_take;
    logic                        w_adv;
    logic                        w_in_fire;

    cct_pkg::t_win_status        w_status;
    cct_pkg::t_charge_out        w_charge;
    logic [cct_pkg::CODE_W-1:0]  w_max_code;
    logic [cct_pkg::CODE_W-1:0]  w_min_code;

    assign w_out_take     = !r_out_valid || o_result.ready;
    assign w_adv          = r_in_valid && w_out_take;
    assign i_sample.ready = !r_in_valid || w_out_take;
    assign w_in_fire      = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_limit <= cct_pkg::VOLTAGE_LIMIT_RST;
            r_window_length <= cct_pkg::WINDOW_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cct_pkg::CFG_VOLTAGE_LIMIT: r_voltage_limit <= i_cfg_data;
                cct_pkg::CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_temp <= i_sample.temp_raw;
            r_in_volt <= i_sample.cell_voltage;
        end
    end

    cct_window #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv),
        .i_temp_raw      (r_in_temp),
        .i_cell_voltage  (r_in_volt),
        .i_voltage_limit (r_voltage_limit),
        .i_window_length (r_window_length),
        .o_status        (w_status),
        .o_max_temp_code (w_max_code),
        .o_min_temp_code (w_min_code)
    );

    cct_charge_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_status (w_status),
        .o_charge (w_charge)
    );

    always_comb begin
        n_res.charge_state  = w_charge.charge_state;
        n_res.overvoltage   = w_charge.overvoltage;
        n_res.bypass        = w_charge.bypass;
        n_res.window_end    = w_status.window_end;
        n_res.max_temp_code = w_max_code;
        n_res.min_temp_code = w_min_code;
    end

    // result register; refills while the previous item is being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_take) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.charge_state  = r_res.charge_state;
    assign o_result.overvoltage   = r_res.overvoltage;
    assign o_result.bypass        = r_res.bypass;
    assign o_result.window_end    = r_res.window_end;
    assign o_result.max_temp_code = r_res.max_temp_code;
    assign o_result.min_temp_code = r_res.min_temp_code;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("stalled sample dropped from input register");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced item did not reach result register");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res.bypass ==
            ((r_res.charge_state == cct_pkg::CODE_CHARGED) || r_res.overvoltage))
        else $error("bypass does not match state and overvoltage");

endmodule
